### rtl/core/topo_enum_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// topo_enum_pkg
// Shared widths, micro-op codes, branch conditions and the control store of
// the topological order enumerator.
// ----------------------------------------------------------------------------
package topo_enum_pkg;

    localparam int MAX_NODES  = 8;
    localparam int NODE_W     = 3;
    localparam int CHOICE_W   = 4;
    localparam int COUNT_W    = 16;
    localparam int ORDER_W    = MAX_NODES * NODE_W;
    localparam int MATRIX_W   = MAX_NODES * MAX_NODES;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRED_MATRIX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCKED     = 2'd2;

    localparam logic [CHOICE_W-1:0] NODE_COUNT_RESET = 4'd8;
    localparam logic [CHOICE_W-1:0] NODE_COUNT_MAX   = 4'd8;

    localparam int OP_W   = 4;
    localparam int COND_W = 4;
    localparam int PC_W   = 5;

    localparam logic [OP_W-1:0] OP_NOP         = 4'd0;
    localparam logic [OP_W-1:0] OP_ACCEPT      = 4'd1;
    localparam logic [OP_W-1:0] OP_CLEAR       = 4'd2;
    localparam logic [OP_W-1:0] OP_SET_EXH     = 4'd3;
    localparam logic [OP_W-1:0] OP_DEC_DEPTH   = 4'd4;
    localparam logic [OP_W-1:0] OP_UNPLACE_INC = 4'd5;
    localparam logic [OP_W-1:0] OP_INC_CHOICE  = 4'd6;
    localparam logic [OP_W-1:0] OP_ADVANCE     = 4'd7;
    localparam logic [OP_W-1:0] OP_EMIT_FOUND  = 4'd8;
    localparam logic [OP_W-1:0] OP_EMIT_EXH    = 4'd9;

    localparam logic [COND_W-1:0] C_NEVER        = 4'd0;
    localparam logic [COND_W-1:0] C_ALWAYS       = 4'd1;
    localparam logic [COND_W-1:0] C_NO_INPUT     = 4'd2;
    localparam logic [COND_W-1:0] C_EXH_OR_NZERO = 4'd3;
    localparam logic [COND_W-1:0] C_DEPTH_GE_N   = 4'd4;
    localparam logic [COND_W-1:0] C_CHOICE_LT_N  = 4'd5;
    localparam logic [COND_W-1:0] C_DEPTH_ZERO   = 4'd6;
    localparam logic [COND_W-1:0] C_CAND_BAD     = 4'd7;
    localparam logic [COND_W-1:0] C_LAST         = 4'd8;
    localparam logic [COND_W-1:0] C_OUT_BUSY     = 4'd9;

    localparam logic [PC_W-1:0] S_WAIT    = 5'd0;
    localparam logic [PC_W-1:0] S_LOOP    = 5'd3;
    localparam logic [PC_W-1:0] S_CAND    = 5'd8;
    localparam logic [PC_W-1:0] S_SKIP    = 5'd11;
    localparam logic [PC_W-1:0] S_FOUND   = 5'd12;
    localparam logic [PC_W-1:0] S_SETEXH  = 5'd14;
    localparam logic [PC_W-1:0] S_EXHWAIT = 5'd15;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [PC_W-1:0]   target;
    } ucode_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            in_ready;
    } ctrl_t;

    typedef struct packed {
        logic exh_or_nzero;
        logic depth_ge_n;
        logic choice_lt_n;
        logic depth_zero;
        logic cand_bad;
        logic last;
        logic out_busy;
    } status_t;

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        unique case (pc)
            5'd0:    w = '{OP_ACCEPT,      C_NO_INPUT,     S_WAIT};
            5'd1:    w = '{OP_CLEAR,       C_NEVER,        S_WAIT};
            5'd2:    w = '{OP_NOP,         C_EXH_OR_NZERO, S_SETEXH};
            5'd3:    w = '{OP_NOP,         C_DEPTH_GE_N,   S_SETEXH};
            5'd4:    w = '{OP_NOP,         C_CHOICE_LT_N,  S_CAND};
            5'd5:    w = '{OP_NOP,         C_DEPTH_ZERO,   S_SETEXH};
            5'd6:    w = '{OP_DEC_DEPTH,   C_NEVER,        S_WAIT};
            5'd7:    w = '{OP_UNPLACE_INC, C_ALWAYS,       S_LOOP};
            5'd8:    w = '{OP_NOP,         C_CAND_BAD,     S_SKIP};
            5'd9:    w = '{OP_NOP,         C_LAST,         S_FOUND};
            5'd10:   w = '{OP_ADVANCE,     C_ALWAYS,       S_LOOP};
            5'd11:   w = '{OP_INC_CHOICE,  C_ALWAYS,       S_LOOP};
            5'd12:   w = '{OP_NOP,         C_OUT_BUSY,     S_FOUND};
            5'd13:   w = '{OP_EMIT_FOUND,  C_ALWAYS,       S_WAIT};
            5'd14:   w = '{OP_SET_EXH,     C_NEVER,        S_WAIT};
            5'd15:   w = '{OP_NOP,         C_OUT_BUSY,     S_EXHWAIT};
            5'd16:   w = '{OP_EMIT_EXH,    C_ALWAYS,       S_WAIT};
            default: w = '{OP_NOP,         C_ALWAYS,       S_WAIT};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

### rtl/core/topo_enum_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// topo_enum_in_if / topo_enum_out_if
// Valid/ready channels for advance requests and for result items.
// ----------------------------------------------------------------------------
interface topo_enum_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface topo_enum_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] ordering;
    logic        found;
    logic [15:0] ordering_number;

    modport source (output valid, output ordering, output found, output ordering_number,
                    input ready);
    modport sink   (input valid, input ordering, input found, input ordering_number,
                    output ready);
endinterface
`default_nettype wire

### rtl/core/topo_enum_useq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// topo_enum_useq
// Micro-sequencer: step counter, control store lookup and conditional jumps.
// ----------------------------------------------------------------------------
module topo_enum_useq
    import topo_enum_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    input  wire status_t status,
    output ctrl_t        ctrl
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    ucode_t          word;
    logic            take;

    assign word = ucode_rom(pc_reg);

    always_comb
    begin
        unique case (word.cond)
            C_NEVER:        take = 1'b0;
            C_ALWAYS:       take = 1'b1;
            C_NO_INPUT:     take = !in_valid;
            C_EXH_OR_NZERO: take = status.exh_or_nzero;
            C_DEPTH_GE_N:   take = status.depth_ge_n;
            C_CHOICE_LT_N:  take = status.choice_lt_n;
            C_DEPTH_ZERO:   take = status.depth_zero;
            C_CAND_BAD:     take = status.cand_bad;
            C_LAST:         take = status.last;
            C_OUT_BUSY:     take = status.out_busy;
            default:        take = 1'b1;
        endcase
        pc_next = take ? word.target : pc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= S_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign ctrl.op       = word.op;
    assign ctrl.in_ready = (pc_reg == S_WAIT);

endmodule
`default_nettype wire

### rtl/core/topo_enum_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// topo_enum_dpath
// Search datapath: configuration, choice stack, depth, placed mask, running count
// and the result register.
// ----------------------------------------------------------------------------
module topo_enum_dpath
    import topo_enum_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire ctrl_t                 ctrl,
    input  wire logic                  in_valid,
    input  wire logic                  in_restart,
    input  wire logic                  out_ready,
    output logic                       out_valid,
    output logic [ORDER_W-1:0]         out_ordering,
    output logic                       out_found,
    output logic [COUNT_W-1:0]         out_number,
    output status_t                    status
);

    logic [CHOICE_W-1:0]  node_count_reg;
    logic [MATRIX_W-1:0]  pred_reg;
    logic [MAX_NODES-1:0] blocked_reg;

    logic [CHOICE_W-1:0]  stack_reg [MAX_NODES];
    logic [NODE_W-1:0]    depth_reg;
    logic [MAX_NODES-1:0] placed_reg;
    logic                 exh_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic                 restart_reg;

    logic                 out_valid_reg;
    logic [ORDER_W-1:0]   out_ordering_reg;
    logic                 out_found_reg;
    logic [COUNT_W-1:0]   out_number_reg;

    logic [CHOICE_W-1:0]  n_eff;
    logic [CHOICE_W-1:0]  choice;
    logic [NODE_W-1:0]    cand;
    logic [MAX_NODES-1:0] cand_row;
    logic [ORDER_W-1:0]   ordering;
    logic                 out_free;
    logic [NODE_W-1:0]    depth_up;

    assign n_eff    = (node_count_reg > NODE_COUNT_MAX) ? NODE_COUNT_MAX : node_count_reg;
    assign choice   = stack_reg[depth_reg];
    assign cand     = choice[NODE_W-1:0];
    assign cand_row = pred_reg[cand*MAX_NODES +: MAX_NODES];
    assign out_free = !out_valid_reg || out_ready;
    assign depth_up = depth_reg + 1'b1;

    always_comb
    begin
        for (int k = 0; k < MAX_NODES; k++)
        begin
            ordering[k*NODE_W +: NODE_W] =
                (CHOICE_W'(k) < n_eff) ? stack_reg[k][NODE_W-1:0] : '0;
        end
    end

    always_comb
    begin
        status.exh_or_nzero = exh_reg || (n_eff == '0);
        status.depth_ge_n   = {1'b0, depth_reg} >= n_eff;
        status.choice_lt_n  = choice < n_eff;
        status.depth_zero   = (depth_reg == '0);
        status.cand_bad     = placed_reg[cand] || blocked_reg[cand]
                              || ((cand_row & ~placed_reg) != '0);
        status.last         = ({1'b0, depth_reg} + 1'b1) >= n_eff;
        status.out_busy     = !out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RESET;
            pred_reg       <= '0;
            blocked_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NODE_COUNT:  node_count_reg <= cfg_data[CHOICE_W-1:0];
                REG_PRED_MATRIX: pred_reg       <= cfg_data[MATRIX_W-1:0];
                REG_BLOCKED:     blocked_reg    <= cfg_data[MAX_NODES-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_NODES; k++)
            begin
                stack_reg[k] <= '0;
            end
            depth_reg   <= '0;
            placed_reg  <= '0;
            exh_reg     <= 1'b0;
            count_reg   <= '0;
            restart_reg <= 1'b0;
        end
        else
        begin
            unique case (ctrl.op)
                OP_ACCEPT:
                begin
                    if (in_valid)
                    begin
                        restart_reg <= in_restart;
                    end
                end
                OP_CLEAR:
                begin
                    if (restart_reg)
                    begin
                        for (int k = 0; k < MAX_NODES; k++)
                        begin
                            stack_reg[k] <= '0;
                        end
                        depth_reg  <= '0;
                        placed_reg <= '0;
                        exh_reg    <= 1'b0;
                        count_reg  <= '0;
                    end
                end
                OP_SET_EXH:     exh_reg <= 1'b1;
                OP_DEC_DEPTH:   depth_reg <= depth_reg - 1'b1;
                OP_UNPLACE_INC:
                begin
                    placed_reg[cand]     <= 1'b0;
                    stack_reg[depth_reg] <= choice + 1'b1;
                end
                OP_INC_CHOICE:  stack_reg[depth_reg] <= choice + 1'b1;
                OP_ADVANCE:
                begin
                    placed_reg[cand]    <= 1'b1;
                    depth_reg           <= depth_up;
                    stack_reg[depth_up] <= '0;
                end
                OP_EMIT_FOUND:
                begin
                    count_reg            <= count_reg + 1'b1;
                    stack_reg[depth_reg] <= choice + 1'b1;
                end
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((ctrl.op == OP_EMIT_FOUND) || (ctrl.op == OP_EMIT_EXH))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.op == OP_EMIT_FOUND)
        begin
            out_ordering_reg <= ordering;
            out_found_reg    <= 1'b1;
            out_number_reg   <= count_reg;
        end
        else if (ctrl.op == OP_EMIT_EXH)
        begin
            out_ordering_reg <= '0;
            out_found_reg    <= 1'b0;
            out_number_reg   <= count_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_ordering = out_ordering_reg;
    assign out_found    = out_found_reg;
    assign out_number   = out_number_reg;

endmodule
`default_nettype wire

### rtl/core/topological_order_enumerator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// topological_order_enumerator
// Enumerates, by backtracking, every ordering of the first node_count nodes
// that respects the configured predecessor matrix and blocked mask.
//
// Each transfer on the input channel is one advance request; restart=1 first
// clears the search and the running count. Exactly one result transfer
// follows on the output channel: the next ordering with found=1 and its
// running number, or found=0 once the search is exhausted.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle; the
// user must keep to that, since the block itself does not enforce it. The
// micro-program takes the request, clears if restart was set, then checks
// each candidate: a rejected one is skipped, a good one is placed and the
// depth advances, and when the choices at a depth run out it backtracks.
// The result sits in an output register and is valid from the cycle after
// its load; while the receiver stalls the sequencer holds before loading
// the next result. The request is taken only while the sequencer waits at
// its first step, so one request is in work at a time.
// Reset clears the search state, restores node_count to 8 and clears the
// matrix and mask; no clearing pass is needed.
// ----------------------------------------------------------------------------
module topological_order_enumerator
    import topo_enum_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    topo_enum_in_if.sink               in,
    topo_enum_out_if.source            out
);

    ctrl_t   ctrl;
    status_t status;

    assign in.ready = ctrl.in_ready;

    topo_enum_useq u_useq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in.valid),
        .status   (status),
        .ctrl     (ctrl)
    );

    topo_enum_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .ctrl         (ctrl),
        .in_valid     (in.valid),
        .in_restart   (in.restart),
        .out_ready    (out.ready),
        .out_valid    (out.valid),
        .out_ordering (out.ordering),
        .out_found    (out.found),
        .out_number   (out.ordering_number),
        .status       (status)
    );

endmodule
`default_nettype wire
